/* sv/frame_header_search_top_assert.svh */
// ----------------------------------------------------------------------------
// frame header search assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FRAME_HEADER_SEARCH_TOP_ASSERT_SVH
`define FRAME_HEADER_SEARCH_TOP_ASSERT_SVH

// checked only while out of reset
`define FHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define FHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/fhs_pkg.sv */
// ----------------------------------------------------------------------------
// fhs_pkg
// types, constants and helpers for the frame header search block
// ----------------------------------------------------------------------------
package fhs_pkg;

  localparam int MAX_HEADER_LEN = 8;
  localparam int HIST_DEPTH     = MAX_HEADER_LEN - 1;
  localparam int HIST_IDX_W     = $clog2(HIST_DEPTH);
  localparam int LEN_W          = 4;
  localparam int PAT_W          = 8 * MAX_HEADER_LEN;
  localparam int POS_W          = 16;
  localparam int OFF_W          = 17;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  localparam logic [LEN_W-1:0]     LEN_RESET = LEN_W'(4);
  localparam logic [POS_W-1:0]     POS_MAX   = '1;
  localparam logic [HIST_IDX_W-1:0] HIST_FULL = HIST_IDX_W'(HIST_DEPTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_PATTERN = CFG_IDX_W'(1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [LEN_W-1:0] header_len;
    logic [PAT_W-1:0] header_pattern;
  } cfg_t;

  // zero counts as one, anything above the maximum as the maximum
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] n;
    n = raw;
    if (n == '0) n = LEN_W'(1);
    if (n > LEN_W'(MAX_HEADER_LEN)) n = LEN_W'(MAX_HEADER_LEN);
    return n;
  endfunction

endpackage

/* sv/fhs_in_stage.sv */
// ----------------------------------------------------------------------------
// fhs_in_stage
// input register for incoming byte beats
// ----------------------------------------------------------------------------
module fhs_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  output logic            beat_valid,
  output fhs_pkg::in_beat_t beat,
  input  logic            beat_take
);
  import fhs_pkg::*;

  logic     valid_r, valid_nxt;
  in_beat_t beat_r;

  assign in_tready  = !valid_r || beat_take;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) valid_nxt = 1'b1;
    else if (beat_take)         valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      beat_r.data_byte <= in_tdata;
      beat_r.last      <= in_tlast;
    end
  end

endmodule

/* sv/fhs_search.sv */
// ----------------------------------------------------------------------------
// fhs_search
// header window compare, search state and result register
// ----------------------------------------------------------------------------
module fhs_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fhs_pkg::cfg_t              cfg,
  input  logic                       beat_valid,
  input  fhs_pkg::in_beat_t          beat,
  output logic                       beat_take,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       res_found,
  output logic [fhs_pkg::OFF_W-1:0]  res_offset
);
  import fhs_pkg::*;

  logic [7:0]            hist_r [HIST_DEPTH];
  logic [7:0]            hist_nxt [HIST_DEPTH];
  logic [HIST_IDX_W-1:0] hcount_r, hcount_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  seen_r, seen_nxt;
  logic                  out_v_r, out_v_nxt;
  logic                  found_r;
  logic [OFF_W-1:0]      offset_r;

  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      len_m1;
  logic [HIST_IDX_W-1:0] idx;
  logic                  match;
  logic                  hit;
  logic                  produce;
  logic                  seen_now;
  logic [OFF_W-1:0]      hit_offset;
  logic [OFF_W-1:0]      miss_offset;

  assign len    = eff_len(cfg.header_len);
  assign len_m1 = len - LEN_W'(1);

  // compare the newest byte and the history window against the header
  always_comb begin
    match = (LEN_W'(hcount_r) >= len_m1) &&
            (beat.data_byte == cfg.header_pattern[8*len_m1[2:0] +: 8]);
    idx   = '0;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      if (LEN_W'(k) < len_m1) begin
        idx = HIST_IDX_W'(len_m1 - LEN_W'(1) - LEN_W'(k));
        if (hist_r[idx] != cfg.header_pattern[8*k +: 8]) match = 1'b0;
      end
    end
  end

  assign beat_take   = beat_valid && (!out_v_r || res_ready);
  assign hit         = !seen_r && match;
  assign produce     = !seen_r && (match || beat.last);
  assign seen_now    = seen_r || match;
  assign hit_offset  = {1'b0, pos_r} - OFF_W'(len_m1);
  assign miss_offset = '0 - OFF_W'(len);

  always_comb begin
    hist_nxt   = hist_r;
    hcount_nxt = hcount_r;
    pos_nxt    = pos_r;
    seen_nxt   = seen_r;
    if (beat_take) begin
      if (!seen_now) begin
        hist_nxt[0] = beat.data_byte;
        for (int i = 1; i < HIST_DEPTH; i++) hist_nxt[i] = hist_r[i-1];
        if (hcount_r != HIST_FULL) hcount_nxt = hcount_r + HIST_IDX_W'(1);
      end
      if (beat.last) begin
        if (seen_now) hcount_nxt = '0;
        pos_nxt  = '0;
        seen_nxt = 1'b0;
      end else begin
        if (pos_r != POS_MAX) pos_nxt = pos_r + POS_W'(1);
        seen_nxt = seen_now;
      end
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (beat_take && produce) out_v_nxt = 1'b1;
    else if (res_ready)       out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcount_r <= '0;
      pos_r    <= '0;
      seen_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hcount_r <= hcount_nxt;
      pos_r    <= pos_nxt;
      seen_r   <= seen_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // entries past the valid count are never compared, so no reset here
  always_ff @(posedge clk) begin
    hist_r <= hist_nxt;
    if (beat_take && produce) begin
      found_r  <= hit;
      offset_r <= hit ? hit_offset : miss_offset;
    end
  end

  assign res_valid  = out_v_r;
  assign res_found  = found_r;
  assign res_offset = offset_r;

endmodule

/* sv/frame_header_search_top.sv */
// ----------------------------------------------------------------------------
// frame_header_search_top
// frame header search over a buffered byte stream
// ----------------------------------------------------------------------------
// One byte beat is taken per clock while the result beat is not stalled,
// with every beat going through an input register, a combinational compare
// of the new byte plus up to seven history bytes against the configured
// header, and a result register. Each buffer (a run of beats closed by
// in_tlast) yields one output beat: found=1 with the header's start offset
// on the byte that completes the first match, or found=0 with offset =
// -header_len on the buffer's last byte. Bytes after a match up to the end
// of the buffer give nothing. A buffer without a match carries its newest
// bytes into the next buffer, so the header may straddle buffers and the
// offset then goes negative; a match clears that carried tail. The byte
// position saturates at 65535. header_len is used as 1 when 0 and as 8
// above 8. The user must write configuration only while the block is idle;
// the block itself does not enforce it. cfg_ready is always high.
// ----------------------------------------------------------------------------
module frame_header_search_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // byte input
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,   // last_in_buffer
  // search result
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // [16:0] offset, [23:17] zero
  output logic                             out_tuser,  // [0] found
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fhs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fhs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fhs_pkg::*;

  logic [LEN_W-1:0] header_len_r;
  logic [PAT_W-1:0] header_pattern_r;
  cfg_t             cfg;

  in_beat_t         beat;
  logic             beat_valid;
  logic             beat_take;
  logic             res_found;
  logic [OFF_W-1:0] res_offset;

  // register file, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_len_r     <= LEN_RESET;
      header_pattern_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_HEADER_LEN)     header_len_r     <= cfg_data[LEN_W-1:0];
      if (cfg_index == CFG_HEADER_PATTERN) header_pattern_r <= cfg_data[PAT_W-1:0];
    end
  end

  assign cfg.header_len     = header_len_r;
  assign cfg.header_pattern = header_pattern_r;

  // input register
  fhs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  // compare, state update and result register
  fhs_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_found  (res_found),
    .res_offset (res_offset)
  );

  // pad the offset to whole bytes
  assign out_tdata = {(24 - OFF_W)'(0), res_offset};
  assign out_tuser = res_found;

endmodule

/* sv/fhs_checker.sv */
// ----------------------------------------------------------------------------
// fhs_checker
// port level checks for the frame header search block
// ----------------------------------------------------------------------------
`include "frame_header_search_top_assert.svh"

module fhs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_ready
);

  // a stalled result beat holds
  `FHS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  // a miss reports minus a header length of one to eight, padding zero
  `FHS_ASSERT(a_miss_offset, out_tvalid && !out_tuser |-> out_tdata[23:17] == 7'h00 && out_tdata[16:3] == 14'h3fff, "bad offset on a buffer without header")

  // with the result register empty the input stage drains, so input is open
  `FHS_ASSERT(a_in_open, !out_tvalid |-> in_tready && cfg_ready, "input stalled with empty result register")

  // no result right after reset
  `FHS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind frame_header_search_top fhs_checker u_fhs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_ready  (cfg_ready)
);
